// ===== hw/rtl/dqsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqsd_pkg
// Types and codes shared by the debounced quadrature step decoder.
// ----------------------------------------------------------------------------
package dqsd_pkg;

	localparam int unsigned POS_W   = 16;
	localparam int unsigned STATE_W = 3;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned STEP_W  = 2;

	localparam logic [POS_W-1:0] POS_MAX = 16'hffff;

	localparam logic [COUNT_W-1:0] DEBOUNCE_LIMIT_RESET = 8'd8;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	localparam logic [STATE_W-1:0] ST_WAIT       = 3'd0;
	localparam logic [STATE_W-1:0] ST_WAIT_ASTAB = 3'd1;
	localparam logic [STATE_W-1:0] ST_WAIT_BSTAB = 3'd2;
	localparam logic [STATE_W-1:0] ST_WAIT_A     = 3'd3;
	localparam logic [STATE_W-1:0] ST_WAIT_B     = 3'd4;
	localparam logic [STATE_W-1:0] ST_CW_DONE    = 3'd5;
	localparam logic [STATE_W-1:0] ST_CCW_DONE   = 3'd6;

	localparam logic [STEP_W-1:0] STEP_NONE = 2'd0;
	localparam logic [STEP_W-1:0] STEP_CW   = 2'd1;
	localparam logic [STEP_W-1:0] STEP_CCW  = 2'd2;

	localparam int unsigned REG_DEBOUNCE_LIMIT = 0;

	typedef struct packed {
		logic             opcode;
		logic             pin_a_level;
		logic             pin_b_level;
		logic [POS_W-1:0] new_position;
	} sample_t;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [STATE_W-1:0] fsm_state;
		logic [STEP_W-1:0]  step_taken;
	} report_t;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic [COUNT_W-1:0] count;
		logic [POS_W-1:0]   position;
	} dec_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dqsd_next.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dqsd_next
// Next-state and report logic for one word: position load, debounce, step
// detection and saturating position update.
// ----------------------------------------------------------------------------
module dqsd_next (
	input  wire  dqsd_pkg::dec_state_t          cur,
	input  wire  logic [dqsd_pkg::COUNT_W-1:0]  limit,
	input  wire  dqsd_pkg::sample_t             item,
	output dqsd_pkg::dec_state_t                nxt,
	output dqsd_pkg::report_t                   rpt
);

	always_comb begin
		logic                         a;
		logic                         b;
		logic [dqsd_pkg::STATE_W-1:0] st;
		logic [dqsd_pkg::COUNT_W-1:0] cnt;
		logic [dqsd_pkg::POS_W-1:0]   pos;
		logic [dqsd_pkg::STEP_W-1:0]  step;

		a    = ~item.pin_a_level;
		b    = ~item.pin_b_level;
		st   = cur.state;
		cnt  = cur.count;
		pos  = cur.position;
		step = dqsd_pkg::STEP_NONE;

		if (item.opcode == dqsd_pkg::OP_LOAD) begin
			pos = item.new_position;
		end else begin
			if (!a && !b) begin
				st  = dqsd_pkg::ST_WAIT;
				cnt = '0;
			end
			if (st == dqsd_pkg::ST_WAIT) begin
				if (a && !b)
					st = dqsd_pkg::ST_WAIT_ASTAB;
				else if (!a && b)
					st = dqsd_pkg::ST_WAIT_BSTAB;
			end
			if (st == dqsd_pkg::ST_WAIT_ASTAB) begin
				if (cnt < limit)
					cnt = cnt + 1'b1;
				else
					st = (a && !b) ? dqsd_pkg::ST_WAIT_B : dqsd_pkg::ST_WAIT;
			end
			if (st == dqsd_pkg::ST_WAIT_BSTAB) begin
				if (cnt < limit)
					cnt = cnt + 1'b1;
				else
					st = (!a && b) ? dqsd_pkg::ST_WAIT_A : dqsd_pkg::ST_WAIT;
			end
			if (st == dqsd_pkg::ST_WAIT_A && a && b) begin
				st   = dqsd_pkg::ST_CCW_DONE;
				step = dqsd_pkg::STEP_CCW;
				if (pos != '0)
					pos = pos - 1'b1;
			end
			if (st == dqsd_pkg::ST_WAIT_B && a && b) begin
				st   = dqsd_pkg::ST_CW_DONE;
				step = dqsd_pkg::STEP_CW;
				if (pos != dqsd_pkg::POS_MAX)
					pos = pos + 1'b1;
			end
		end

		nxt.state      = st;
		nxt.count      = cnt;
		nxt.position   = pos;
		rpt.position   = pos;
		rpt.fsm_state  = st;
		rpt.step_taken = step;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/debounced_quadrature_step_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_quadrature_step_decoder_unit
// Debounced decoder for a two-pin quadrature encoder with a loadable,
// saturating 16-bit position and an APB-style register port.
// ----------------------------------------------------------------------------
//  Channel   Handshake                     Word
//  sample    sample_valid / sample_ready   sample_t (opcode, pins, position)
//  report    report_valid / report_ready   report_t (position, state, step)
//  config    psel / penable / pwrite       debounce_limit at byte address 0
//
//  A word is registered on acceptance and its report is registered once the report side advances.
//  One word is accepted every cycle while the report side keeps taking words.
//  The rate is set by the combinational next-state logic of the decoder.
//  Reset clears the decoder state, count and position and sets the limit to 8.
//  A stalled report holds both pipeline registers; nothing is dropped.
// ----------------------------------------------------------------------------
module debounced_quadrature_step_decoder_unit (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              sample_valid,
	output logic                    sample_ready,
	input  wire  dqsd_pkg::sample_t sample,
	output logic                    report_valid,
	input  wire  logic              report_ready,
	output dqsd_pkg::report_t       report,
	input  wire  logic              psel,
	input  wire  logic              penable,
	input  wire  logic              pwrite,
	input  wire  logic [2:0]        paddr,
	input  wire  logic [31:0]       pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic                         item_valid_s1;
	dqsd_pkg::sample_t            item_s1;
	dqsd_pkg::dec_state_t         dec_q;
	dqsd_pkg::dec_state_t         dec_next;
	dqsd_pkg::report_t            rpt_next;
	logic [dqsd_pkg::COUNT_W-1:0] limit_q;
	logic                         advance;
	logic                         fire;
	logic                         reg_sel;

	assign reg_sel      = (paddr[2] == 1'(dqsd_pkg::REG_DEBOUNCE_LIMIT));
	assign pready       = 1'b1;
	assign prdata       = reg_sel ? {24'd0, limit_q} : 32'd0;

	assign advance      = !report_valid || report_ready;
	assign fire         = item_valid_s1 && advance;
	assign sample_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= dqsd_pkg::DEBOUNCE_LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			limit_q <= pwdata[dqsd_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			item_valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid)
			item_s1 <= sample;
	end

	dqsd_next u_next (
		.cur   (dec_q),
		.limit (limit_q),
		.item  (item_s1),
		.nxt   (dec_next),
		.rpt   (rpt_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q.state    <= dqsd_pkg::ST_WAIT;
			dec_q.count    <= '0;
			dec_q.position <= '0;
			report_valid   <= 1'b0;
		end else begin
			if (fire)
				dec_q <= dec_next;
			if (advance)
				report_valid <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			report <= rpt_next;
	end

	a_cw_state: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report.step_taken == dqsd_pkg::STEP_CW
		|-> report.fsm_state == dqsd_pkg::ST_CW_DONE)
		else $error("clockwise step reported outside cw done");

	a_ccw_state: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report.step_taken == dqsd_pkg::STEP_CCW
		|-> report.fsm_state == dqsd_pkg::ST_CCW_DONE)
		else $error("counter-clockwise step reported outside ccw done");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.opcode == dqsd_pkg::OP_LOAD
		|=> report.position == $past(item_s1.new_position)
			&& report.step_taken == dqsd_pkg::STEP_NONE)
		else $error("load word did not report the loaded position");

	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.opcode == dqsd_pkg::OP_SAMPLE
			&& item_s1.pin_a_level && item_s1.pin_b_level
		|=> dec_q.count == '0 && dec_q.state == dqsd_pkg::ST_WAIT)
		else $error("inactive pins did not return the decoder to wait");

	a_report_pos: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fire) |-> report.position == dec_q.position)
		else $error("reported position differs from the stored position");

endmodule
`default_nettype wire

// ===== tb/tb_debounced_quadrature_step_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_debounced_quadrature_step_decoder_unit
// Drives sample and load words into the decoder and checks every report word
// against an in-bench model of the debounce and direction state machine.
// Stimulus is a directed set of corner cases, followed by random encoder
// detents with glitches and loads. These run at several debounce limits,
// with stalls on both handshakes and a long hold-off on the report side.
// ----------------------------------------------------------------------------
module tb_debounced_quadrature_step_decoder_unit;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_LEN    = 60;
	localparam int unsigned MAX_SHOWN   = 10;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	dqsd_pkg::sample_t sample       = '0;
	logic              report_valid;
	logic              report_ready = 1'b0;
	dqsd_pkg::report_t report;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [2:0]        paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;

	dqsd_pkg::report_t            expected_reports[$];
	dqsd_pkg::report_t            oldest;
	dqsd_pkg::dec_state_t         tracked =
		'{state: dqsd_pkg::ST_WAIT, count: '0, position: '0};
	logic [dqsd_pkg::COUNT_W-1:0] tracked_limit = dqsd_pkg::DEBOUNCE_LIMIT_RESET;

	int unsigned send_idle_pct = 0;
	int unsigned rcv_idle_pct  = 0;
	int unsigned stall_asked   = 0;
	int unsigned stall_served  = 0;
	int unsigned hold_left     = 0;
	int unsigned words_sent    = 0;
	int unsigned reports_seen  = 0;
	int unsigned mismatches    = 0;
	int unsigned cw_steps      = 0;
	int unsigned ccw_steps     = 0;
	int unsigned cycle_count   = 0;

	debounced_quadrature_step_decoder_unit dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic dqsd_pkg::report_t decode_word(input dqsd_pkg::sample_t w);
		logic                        a_on;
		logic                        b_on;
		logic [dqsd_pkg::STEP_W-1:0] step;
		a_on = ~w.pin_a_level;
		b_on = ~w.pin_b_level;
		step = dqsd_pkg::STEP_NONE;
		if (w.opcode == dqsd_pkg::OP_LOAD) begin
			tracked.position = w.new_position;
		end else begin
			if (!a_on && !b_on) begin
				tracked.state = dqsd_pkg::ST_WAIT;
				tracked.count = '0;
			end
			if (tracked.state == dqsd_pkg::ST_WAIT) begin
				if (a_on && !b_on)
					tracked.state = dqsd_pkg::ST_WAIT_ASTAB;
				else if (!a_on && b_on)
					tracked.state = dqsd_pkg::ST_WAIT_BSTAB;
			end
			if (tracked.state == dqsd_pkg::ST_WAIT_ASTAB) begin
				if (tracked.count < tracked_limit)
					tracked.count = tracked.count + 1'b1;
				else
					tracked.state = (a_on && !b_on) ? dqsd_pkg::ST_WAIT_B
						: dqsd_pkg::ST_WAIT;
			end
			if (tracked.state == dqsd_pkg::ST_WAIT_BSTAB) begin
				if (tracked.count < tracked_limit)
					tracked.count = tracked.count + 1'b1;
				else
					tracked.state = (!a_on && b_on) ? dqsd_pkg::ST_WAIT_A
						: dqsd_pkg::ST_WAIT;
			end
			if (tracked.state == dqsd_pkg::ST_WAIT_A && a_on && b_on) begin
				tracked.state = dqsd_pkg::ST_CCW_DONE;
				if (tracked.position != '0)
					tracked.position = tracked.position - 1'b1;
				step = dqsd_pkg::STEP_CCW;
				ccw_steps++;
			end
			if (tracked.state == dqsd_pkg::ST_WAIT_B && a_on && b_on) begin
				tracked.state = dqsd_pkg::ST_CW_DONE;
				if (tracked.position != dqsd_pkg::POS_MAX)
					tracked.position = tracked.position + 1'b1;
				step = dqsd_pkg::STEP_CW;
				cw_steps++;
			end
		end
		return '{position: tracked.position, fsm_state: tracked.state, step_taken: step};
	endfunction

	task automatic send_word(input dqsd_pkg::sample_t w);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= w;
		do @(posedge clk); while (!sample_ready);
		expected_reports.push_back(decode_word(w));
		words_sent++;
	endtask

	task automatic send_pins(input logic a_act, input logic b_act);
		dqsd_pkg::sample_t w;
		w.opcode = dqsd_pkg::OP_SAMPLE;
		w.pin_a_level = ~a_act;
		w.pin_b_level = ~b_act;
		w.new_position = 16'($urandom);
		send_word(w);
	endtask

	task automatic send_load(input logic [dqsd_pkg::POS_W-1:0] value, input logic a_lvl,
			input logic b_lvl);
		dqsd_pkg::sample_t w;
		w.opcode = dqsd_pkg::OP_LOAD;
		w.pin_a_level = a_lvl;
		w.pin_b_level = b_lvl;
		w.new_position = value;
		send_word(w);
	endtask

	task automatic wait_drained;
		sample_valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input logic [dqsd_pkg::COUNT_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * dqsd_pkg::REG_DEBOUNCE_LIMIT);
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracked_limit = value;
		@(posedge clk);
	endtask

	task automatic run_random(input int unsigned n);
		int unsigned                 first_word;
		int unsigned                 pick;
		int unsigned                 run_len;
		logic                        a_lead;
		logic [dqsd_pkg::POS_W-1:0]  load_val;
		first_word = words_sent;
		while (words_sent - first_word < n) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				a_lead = 1'($urandom_range(1));
				repeat ($urandom_range(1, 2)) send_pins(1'b0, 1'b0);
				if ($urandom_range(4) == 0)
					run_len = $urandom_range(1, int'(tracked_limit) + 1);
				else
					run_len = int'(tracked_limit) + 1 + $urandom_range(2);
				repeat (run_len) send_pins(a_lead, !a_lead);
				repeat ($urandom_range(1, 3)) send_pins(1'b1, 1'b1);
				repeat ($urandom_range(2)) send_pins(!a_lead, a_lead);
				send_pins(1'b0, 1'b0);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) send_pins(1'($urandom), 1'($urandom));
			end else begin
				case ($urandom_range(4))
					0: load_val = '0;
					1: load_val = 16'd1;
					2: load_val = dqsd_pkg::POS_MAX - 1'b1;
					3: load_val = dqsd_pkg::POS_MAX;
					default: load_val = 16'($urandom);
				endcase
				send_load(load_val, 1'($urandom), 1'($urandom));
			end
		end
	endtask

	task automatic test_load_and_saturation;
		write_limit(8'd1);
		send_load(dqsd_pkg::POS_MAX, 1'b0, 1'b0);
		repeat (3) send_pins(1'b1, 1'b0);
		send_pins(1'b1, 1'b1);
		send_pins(1'b0, 1'b0);
		send_load('0, 1'b1, 1'b1);
		repeat (2) send_pins(1'b0, 1'b1);
		send_pins(1'b1, 1'b1);
		send_pins(1'b0, 1'b0);
	endtask

	task automatic test_done_hold;
		repeat (2) send_pins(1'b1, 1'b0);
		send_pins(1'b1, 1'b1);
		send_pins(1'b0, 1'b1);
		send_pins(1'b1, 1'b0);
		send_pins(1'b1, 1'b1);
	endtask

	task automatic test_kept_count;
		send_pins(1'b0, 1'b0);
		send_pins(1'b1, 1'b0);
		repeat (2) send_pins(1'b0, 1'b1);
		send_pins(1'b1, 1'b1);
	endtask

	task automatic test_lowered_limit;
		wait_drained();
		write_limit(8'd200);
		send_pins(1'b0, 1'b0);
		repeat (3) send_pins(1'b1, 1'b0);
		wait_drained();
		write_limit('0);
		send_pins(1'b1, 1'b0);
		send_pins(1'b1, 1'b1);
		send_pins(1'b0, 1'b0);
		send_pins(1'b0, 1'b1);
		send_pins(1'b1, 1'b1);
	endtask

	task automatic test_random_default_limit;
		wait_drained();
		write_limit(dqsd_pkg::DEBOUNCE_LIMIT_RESET);
		run_random(300);
	endtask

	task automatic test_random_max_limit;
		wait_drained();
		write_limit(8'hff);
		run_random(150);
	endtask

	task automatic test_random_zero_limit;
		wait_drained();
		write_limit('0);
		run_random(250);
	endtask

	task automatic test_backpressure;
		wait_drained();
		write_limit(8'($urandom_range(1, 5)));
		stall_asked <= stall_asked + 1;
		run_random(300);
	endtask

	always @(posedge clk) begin
		if (arst_n && report_valid && report_ready) begin
			reports_seen++;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("Unexpected report word: position %h state %0d step %0d",
						report.position, report.fsm_state, report.step_taken);
			end else begin
				oldest = expected_reports.pop_front();
				if (report.position !== oldest.position ||
						report.fsm_state !== oldest.fsm_state ||
						report.step_taken !== oldest.step_taken) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("Report word %0d differs: expected position %h state %0d ",
							reports_seen, oldest.position, oldest.fsm_state,
							"step %0d, got position %h state %0d step %0d",
							oldest.step_taken, report.position, report.fsm_state,
							report.step_taken);
				end
			end
		end
		if (stall_served != stall_asked) begin
			stall_served <= stall_asked;
			hold_left <= HOLD_LEN - 1;
			report_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			report_ready <= 1'b0;
		end else begin
			report_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d words outstanding.",
				cycle_count, expected_reports.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 21;
		rcv_idle_pct <= 57;
		test_load_and_saturation();
		test_done_hold();
		test_kept_count();
		test_lowered_limit();
		test_random_default_limit();
		send_idle_pct = 57;
		rcv_idle_pct <= 21;
		test_random_max_limit();
		test_random_zero_limit();
		send_idle_pct = 0;
		rcv_idle_pct <= 0;
		test_backpressure();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d words (pin samples and position loads) at debounce limits ",
			words_sent, "0, 1, 8, 200, 255 and a small random one, with stalls on both sides.");
		$display("Checked %0d reports holding %0d clockwise and %0d counter-clockwise steps.",
			reports_seen, cw_steps, ccw_steps);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
